FILE: rtl/core/gmd_pkg.sv
// Shared types and constants of the gzip member deframer.
`default_nettype none

package gmd_pkg;

  // Header parser phases, one-hot
  typedef enum logic [12:0] {
    PH_MAGIC0  = 13'b0000000000001,
    PH_MAGIC1  = 13'b0000000000010,
    PH_METHOD  = 13'b0000000000100,
    PH_FLAGS   = 13'b0000000001000,
    PH_FIXED   = 13'b0000000010000,
    PH_XLEN0   = 13'b0000000100000,
    PH_XLEN1   = 13'b0000001000000,
    PH_EXTRA   = 13'b0000010000000,
    PH_NAME    = 13'b0000100000000,
    PH_COMMENT = 13'b0001000000000,
    PH_HCRC    = 13'b0010000000000,
    PH_PAYLOAD = 13'b0100000000000,
    PH_DROP    = 13'b1000000000000
  } phase_t;

  // Final status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MAGIC    = 3'd1;
  localparam logic [2:0] ST_METHOD   = 3'd2;
  localparam logic [2:0] ST_RESERVED = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;

  // Header constants
  localparam logic [7:0] MAGIC_BYTE0    = 8'h1f;
  localparam logic [7:0] MAGIC_BYTE1    = 8'h8b;
  localparam logic [7:0] METHOD_DEFLATE = 8'd8;
  localparam logic [7:0] FL_RESERVED    = 8'hE0;
  localparam int         FL_HCRC_BIT    = 1;
  localparam int         FL_EXTRA_BIT   = 2;
  localparam int         FL_NAME_BIT    = 3;
  localparam int         FL_COMMENT_BIT = 4;
  localparam logic [3:0] FIXED_START    = 4'd4;
  localparam logic [3:0] FIXED_END      = 4'd10;
  localparam logic [3:0] HCRC_END       = 4'd2;

  // Trailer delay line
  localparam int         TAIL_LEN  = 8;
  localparam logic [3:0] TAIL_FULL = 4'd8;

  // Header section levels for the section search
  localparam logic [1:0] LVL_EXTRA   = 2'd0;
  localparam logic [1:0] LVL_NAME    = 2'd1;
  localparam logic [1:0] LVL_COMMENT = 2'd2;
  localparam logic [1:0] LVL_HCRC    = 2'd3;

  // Output packing
  localparam int OUT_TDATA_W = 112;

  localparam int GMD_QUEUE_DEPTH = 4;

  // Classified item handed from the parser to the trailer stage
  typedef struct packed {
    logic [7:0] data;
    logic       pay;       // payload byte
    logic       last;      // final byte of the member
    logic [2:0] err;       // error code after this byte
    logic       hdr_done;  // header complete after this byte
  } gmd_entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/gzip_member_deframer_core.sv
// gzip member deframer: header parser, item queue and trailer stage.
//
// Input channel in_*: one byte of a gzip member per item, in_tlast on the
// member's final byte. Result channel out_*: payload bytes (out_tuser = 0)
// and one closing status item per member (out_tuser = 1, out_tlast = 1)
// with status, trailer CRC-32 and size, and the payload byte count.
// The parser checks magic, method and reserved flags and skips the fixed
// header, extra field, name, comment and header CRC. Payload runs through an
// 8-byte delay line so the trailer is never passed on as payload.
// Throughput: one byte per cycle while the queue has room. A result is
// registered from the item at the head of the 4-entry queue; the final byte
// of a member can produce two results and holds the trailer stage for both.
// Stall: when out_tready is low the result register holds, the queue fills,
// and in_tready drops once the queue is full.
// Reset: the parser returns to the first magic byte, the queue empties and
// no result is valid. After every closing item all member state clears.
`default_nettype none

module gzip_member_deframer_core
  import gmd_pkg::*;
#(
  parameter int QUEUE_DEPTH = GMD_QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // [7:0] in_byte
  input  wire logic                   in_tlast,   // in_last
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [7:0] out_byte, [10:8] status, [42:11] expected_crc,
  // [74:43] trailer_size, [106:75] payload_length, [111:107] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tuser,  // item_kind
  output logic                        out_tlast   // is_final
);

  gmd_entry_t push_entry;
  gmd_entry_t head;
  logic       q_push, q_full, q_pop, q_empty;

  gmd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  gmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (head),
    .empty      (q_empty)
  );

  gmd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/core/gmd_front.sv
// Header parser: accepts bytes, walks the gzip header and classifies each byte.
`default_nettype none

module gmd_front
  import gmd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // in_last
  input  wire logic       q_full,
  output logic            q_push,
  output gmd_entry_t      q_entry
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [4:0]  flags_r, flags_nxt;
  logic [15:0] extra_r, extra_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        accept;
  logic        is_pay;

  function automatic phase_t next_section(input logic [1:0] level, input logic [4:0] fl);
    phase_t ph;
    if (level <= LVL_EXTRA && fl[FL_EXTRA_BIT]) ph = PH_XLEN0;
    else if (level <= LVL_NAME && fl[FL_NAME_BIT]) ph = PH_NAME;
    else if (level <= LVL_COMMENT && fl[FL_COMMENT_BIT]) ph = PH_COMMENT;
    else if (level <= LVL_HCRC && fl[FL_HCRC_BIT]) ph = PH_HCRC;
    else ph = PH_PAYLOAD;
    return ph;
  endfunction

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    flags_nxt = flags_r;
    extra_nxt = extra_r;
    err_nxt   = err_r;
    is_pay    = 1'b0;
    case (phase_r)
      PH_MAGIC0: begin
        if (in_tdata == MAGIC_BYTE0) phase_nxt = PH_MAGIC1;
        else begin
          err_nxt   = ST_MAGIC;
          phase_nxt = PH_DROP;
        end
      end
      PH_MAGIC1: begin
        if (in_tdata == MAGIC_BYTE1) phase_nxt = PH_METHOD;
        else begin
          err_nxt   = ST_MAGIC;
          phase_nxt = PH_DROP;
        end
      end
      PH_METHOD: begin
        if (in_tdata == METHOD_DEFLATE) phase_nxt = PH_FLAGS;
        else begin
          err_nxt   = ST_METHOD;
          phase_nxt = PH_DROP;
        end
      end
      PH_FLAGS: begin
        if ((in_tdata & FL_RESERVED) != 8'd0) begin
          err_nxt   = ST_RESERVED;
          phase_nxt = PH_DROP;
        end else begin
          flags_nxt = in_tdata[4:0];
          idx_nxt   = FIXED_START;
          phase_nxt = PH_FIXED;
        end
      end
      PH_FIXED: begin
        idx_nxt = idx_r + 4'd1;
        if (idx_nxt >= FIXED_END) phase_nxt = next_section(LVL_EXTRA, flags_r);
      end
      PH_XLEN0: begin
        extra_nxt = {8'd0, in_tdata};
        phase_nxt = PH_XLEN1;
      end
      PH_XLEN1: begin
        extra_nxt = {in_tdata, extra_r[7:0]};
        if (extra_nxt == 16'd0) phase_nxt = next_section(LVL_NAME, flags_r);
        else phase_nxt = PH_EXTRA;
      end
      PH_EXTRA: begin
        extra_nxt = extra_r - 16'd1;
        if (extra_nxt == 16'd0) phase_nxt = next_section(LVL_NAME, flags_r);
      end
      PH_NAME: begin
        if (in_tdata == 8'd0) phase_nxt = next_section(LVL_COMMENT, flags_r);
      end
      PH_COMMENT: begin
        if (in_tdata == 8'd0) phase_nxt = next_section(LVL_HCRC, flags_r);
      end
      PH_HCRC: begin
        idx_nxt = idx_r + 4'd1;
        if (idx_nxt >= HCRC_END) phase_nxt = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        is_pay = 1'b1;
      end
      PH_DROP: begin
      end
      default: begin
      end
    endcase
    // restart the header crc byte count on entry
    if (phase_nxt == PH_HCRC && phase_r != PH_HCRC) idx_nxt = 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC0;
      idx_r   <= 4'd0;
      flags_r <= 5'd0;
      extra_r <= 16'd0;
      err_r   <= ST_OK;
    end else if (accept) begin
      if (in_tlast) begin
        // member ends: back to the start for the next one
        phase_r <= PH_MAGIC0;
        idx_r   <= 4'd0;
        flags_r <= 5'd0;
        extra_r <= 16'd0;
        err_r   <= ST_OK;
      end else begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        flags_r <= flags_nxt;
        extra_r <= extra_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  // header and dropped bytes cause no result unless they carry the last mark
  assign q_push           = accept && (is_pay || in_tlast);
  assign q_entry.data     = in_tdata;
  assign q_entry.pay      = is_pay;
  assign q_entry.last     = in_tlast;
  assign q_entry.err      = err_nxt;
  assign q_entry.hdr_done = (phase_nxt == PH_PAYLOAD);

endmodule

`default_nettype wire

FILE: rtl/core/gmd_queue.sv
// Short FIFO of classified items between the parser and the trailer stage.
`default_nettype none

module gmd_queue
  import gmd_pkg::*;
#(
  parameter int DEPTH = GMD_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire gmd_entry_t push_entry,
  output logic            full,
  input  wire logic       pop,
  output gmd_entry_t      head,
  output logic            empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  gmd_entry_t       mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      if (wr_ptr_r == AW'(DEPTH - 1)) wr_ptr_nxt = '0;
      else wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      if (rd_ptr_r == AW'(DEPTH - 1)) rd_ptr_nxt = '0;
      else rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

`default_nettype wire

FILE: rtl/core/gmd_back.sv
// Trailer stage: 8-byte delay line, payload count and result register.
`default_nettype none

module gmd_back
  import gmd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire gmd_entry_t             head,
  input  wire logic                   q_empty,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tuser,
  output logic                        out_tlast
);

  logic [7:0]  tail_r [TAIL_LEN];
  logic [7:0]  tail_nxt [TAIL_LEN];
  logic [7:0]  tail_sh [TAIL_LEN];
  logic [7:0]  tail_fin [TAIL_LEN];
  logic [3:0]  fill_r, fill_nxt;
  logic [31:0] count_r, count_nxt;
  logic        pay_done_r, pay_done_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        kind_r, kind_nxt;
  logic        final_r, final_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] len_r, len_nxt;
  logic        can_load, go, fill_full, emit_pay, absorb;
  logic [3:0]  fill_fin;
  logic [2:0]  st;

  assign can_load  = !out_valid_r || out_tready;
  assign go        = can_load && !q_empty;
  assign fill_full = (fill_r >= TAIL_FULL);
  assign emit_pay  = head.pay && fill_full && !pay_done_r;
  assign absorb    = head.pay && !fill_full && !pay_done_r;

  always_comb begin
    for (int i = 0; i < TAIL_LEN - 1; i++) tail_sh[i] = tail_r[i + 1];
    tail_sh[TAIL_LEN - 1] = head.data;
    for (int i = 0; i < TAIL_LEN; i++) tail_fin[i] = absorb ? tail_sh[i] : tail_r[i];
  end

  assign fill_fin = absorb ? (fill_r + 4'd1) : fill_r;

  always_comb begin
    if (head.err != ST_OK) st = head.err;
    else if (!head.hdr_done || fill_fin < TAIL_FULL) st = ST_TRUNC;
    else st = ST_OK;
  end

  always_comb begin
    for (int i = 0; i < TAIL_LEN; i++) tail_nxt[i] = tail_r[i];
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    pay_done_nxt  = pay_done_r;
    out_valid_nxt = out_valid_r && !out_tready;
    kind_nxt      = kind_r;
    final_nxt     = final_r;
    byte_nxt      = byte_r;
    status_nxt    = status_r;
    crc_nxt       = crc_r;
    size_nxt      = size_r;
    len_nxt       = len_r;
    q_pop         = 1'b0;
    if (go) begin
      if (emit_pay) begin
        // oldest held byte leaves the delay line as payload
        out_valid_nxt = 1'b1;
        kind_nxt      = 1'b0;
        final_nxt     = 1'b0;
        byte_nxt      = tail_r[0];
        status_nxt    = ST_OK;
        crc_nxt       = 32'd0;
        size_nxt      = 32'd0;
        len_nxt       = 32'd0;
        for (int i = 0; i < TAIL_LEN; i++) tail_nxt[i] = tail_sh[i];
        count_nxt = count_r + 32'd1;
        if (head.last) pay_done_nxt = 1'b1;
        else q_pop = 1'b1;
      end else begin
        if (absorb) begin
          for (int i = 0; i < TAIL_LEN; i++) tail_nxt[i] = tail_sh[i];
          fill_nxt = fill_r + 4'd1;
        end
        if (head.last) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = 1'b1;
          final_nxt     = 1'b1;
          byte_nxt      = 8'd0;
          status_nxt    = st;
          crc_nxt       = (st == ST_OK) ?
                          {tail_fin[3], tail_fin[2], tail_fin[1], tail_fin[0]} : 32'd0;
          size_nxt      = (st == ST_OK) ?
                          {tail_fin[7], tail_fin[6], tail_fin[5], tail_fin[4]} : 32'd0;
          len_nxt       = count_r;
          fill_nxt      = 4'd0;
          count_nxt     = 32'd0;
          pay_done_nxt  = 1'b0;
        end
        q_pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= 4'd0;
      count_r     <= 32'd0;
      pay_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      pay_done_r  <= pay_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TAIL_LEN; i++) tail_r[i] <= tail_nxt[i];
    kind_r   <= kind_nxt;
    final_r  <= final_nxt;
    byte_r   <= byte_nxt;
    status_r <= status_nxt;
    crc_r    <= crc_nxt;
    size_r   <= size_nxt;
    len_r    <= len_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = final_r;
  assign out_tdata  = {5'd0, len_r, size_r, crc_r, status_r, byte_r};

endmodule

`default_nettype wire

FILE: dv/gzip_member_deframer_core_tb.sv
// Self-checking testbench for the gzip member deframer core.
`default_nettype none

module gzip_member_deframer_core_tb;
  import gmd_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct {
    logic        kind;
    logic [7:0]  pbyte;
    logic [2:0]  status;
    logic [31:0] crc;
    logic [31:0] size;
    logic [31:0] plen;
    logic        fin;
  } deframe_result_t;

  typedef enum {MB_GOOD, MB_CUT, MB_BAD, MB_NOISE} member_shape_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'h00;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  gzip_member_deframer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  in_item_t        byte_queue[$];
  logic [7:0]      member_bytes[$];
  deframe_result_t due_results[$];
  in_item_t        next_in;
  logic            in_took = 1'b0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int members_sent   = 0;
  int bytes_queued   = 0;
  int payload_seen   = 0;
  int status_seen    = 0;

  // Deframer state as predicted
  phase_t      dp_phase;
  logic [3:0]  dp_hidx;
  logic [4:0]  dp_flags;
  logic [15:0] dp_xrem;
  logic [7:0]  dp_tail[8];
  logic [3:0]  dp_fill;
  logic [2:0]  dp_err;
  logic [31:0] dp_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_deframer();
    dp_phase = PH_MAGIC0;
    dp_hidx  = '0;
    dp_flags = '0;
    dp_xrem  = '0;
    dp_fill  = '0;
    dp_err   = ST_OK;
    dp_count = '0;
    for (int i = 0; i < TAIL_LEN; i++) dp_tail[i] = 8'h00;
  endfunction

  function automatic void flag_error(input logic [2:0] code);
    dp_err   = code;
    dp_phase = PH_DROP;
  endfunction

  // Move to the first present header section at or after the given level
  function automatic void enter_section(input logic [1:0] lvl);
    if (lvl <= LVL_EXTRA && dp_flags[FL_EXTRA_BIT]) dp_phase = PH_XLEN0;
    else if (lvl <= LVL_NAME && dp_flags[FL_NAME_BIT]) dp_phase = PH_NAME;
    else if (lvl <= LVL_COMMENT && dp_flags[FL_COMMENT_BIT]) dp_phase = PH_COMMENT;
    else if (lvl <= LVL_HCRC && dp_flags[FL_HCRC_BIT]) begin
      dp_phase = PH_HCRC;
      dp_hidx  = '0;
    end else dp_phase = PH_PAYLOAD;
  endfunction

  function automatic void advance_deframer(input logic [7:0] b, input logic last);
    deframe_result_t r;
    logic [2:0]      st;
    r = '{kind: 1'b0, pbyte: 8'h00, status: ST_OK, crc: '0, size: '0, plen: '0, fin: 1'b0};
    case (dp_phase)
      PH_MAGIC0: if (b == MAGIC_BYTE0) dp_phase = PH_MAGIC1; else flag_error(ST_MAGIC);
      PH_MAGIC1: if (b == MAGIC_BYTE1) dp_phase = PH_METHOD; else flag_error(ST_MAGIC);
      PH_METHOD: if (b == METHOD_DEFLATE) dp_phase = PH_FLAGS; else flag_error(ST_METHOD);
      PH_FLAGS: begin
        if ((b & FL_RESERVED) != 8'h00) flag_error(ST_RESERVED);
        else begin
          dp_flags = b[4:0];
          dp_hidx  = FIXED_START;
          dp_phase = PH_FIXED;
        end
      end
      PH_FIXED: begin
        dp_hidx = dp_hidx + 4'd1;
        if (dp_hidx >= FIXED_END) enter_section(LVL_EXTRA);
      end
      PH_XLEN0: begin
        dp_xrem  = {8'h00, b};
        dp_phase = PH_XLEN1;
      end
      PH_XLEN1: begin
        dp_xrem[15:8] = b;
        if (dp_xrem == 16'd0) enter_section(LVL_NAME);
        else dp_phase = PH_EXTRA;
      end
      PH_EXTRA: begin
        dp_xrem = dp_xrem - 16'd1;
        if (dp_xrem == 16'd0) enter_section(LVL_NAME);
      end
      PH_NAME:    if (b == 8'h00) enter_section(LVL_COMMENT);
      PH_COMMENT: if (b == 8'h00) enter_section(LVL_HCRC);
      PH_HCRC: begin
        dp_hidx = dp_hidx + 4'd1;
        if (dp_hidx >= HCRC_END) dp_phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (dp_fill >= TAIL_FULL) begin
          // release the oldest held byte, shift the new one in
          r.pbyte = dp_tail[0];
          due_results.push_back(r);
          dp_count = dp_count + 32'd1;
          for (int i = 0; i < TAIL_LEN - 1; i++) dp_tail[i] = dp_tail[i + 1];
          dp_tail[TAIL_LEN - 1] = b;
        end else begin
          dp_tail[dp_fill[2:0]] = b;
          dp_fill = dp_fill + 4'd1;
        end
      end
      default: ;
    endcase

    if (last) begin
      if (dp_err != ST_OK) st = dp_err;
      else if (dp_phase != PH_PAYLOAD || dp_fill < TAIL_FULL) st = ST_TRUNC;
      else st = ST_OK;
      r.kind   = 1'b1;
      r.pbyte  = 8'h00;
      r.status = st;
      r.crc    = (st == ST_OK) ? {dp_tail[3], dp_tail[2], dp_tail[1], dp_tail[0]} : 32'd0;
      r.size   = (st == ST_OK) ? {dp_tail[7], dp_tail[6], dp_tail[5], dp_tail[4]} : 32'd0;
      r.plen   = dp_count;
      r.fin    = 1'b1;
      due_results.push_back(r);
      clear_deframer();
    end
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: mismatch: %s", $realtime, msg);
  endfunction

  function automatic void check_result();
    deframe_result_t want;
    logic [7:0]      got_byte;
    logic [2:0]      got_st;
    logic [31:0]     got_crc, got_size, got_plen;
    logic [4:0]      got_pad;
    got_byte = out_tdata[7:0];
    got_st   = out_tdata[10:8];
    got_crc  = out_tdata[42:11];
    got_size = out_tdata[74:43];
    got_plen = out_tdata[106:75];
    got_pad  = out_tdata[111:107];
    if (out_tuser) status_seen++; else payload_seen++;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("unexpected item kind %0d byte %02h status %0d",
                                out_tuser, got_byte, got_st));
      return;
    end
    want = due_results.pop_front();
    if (out_tuser !== want.kind || got_byte !== want.pbyte || got_st !== want.status ||
        got_crc !== want.crc || got_size !== want.size || got_plen !== want.plen ||
        out_tlast !== want.fin || got_pad !== 5'd0)
      report_mismatch($sformatf({"exp kind %0d byte %02h st %0d crc %08h size %08h len %0d ",
                                 "last %0d / got kind %0d byte %02h st %0d crc %08h ",
                                 "size %08h len %0d last %0d pad %02h"},
                                want.kind, want.pbyte, want.status, want.crc, want.size,
                                want.plen, want.fin, out_tuser, got_byte, got_st, got_crc,
                                got_size, got_plen, out_tlast, got_pad));
  endfunction

  // Input side: present a new byte once the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_in = byte_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_in.data;
        in_tlast  <= next_in.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      in_took <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) advance_deframer(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_result();
    end
  end

  // Hand the assembled member to the driver, last mark on its final byte
  task automatic flush_member();
    in_item_t it;
    for (int i = 0; i < member_bytes.size(); i++) begin
      it.data = member_bytes[i];
      it.last = (i == member_bytes.size() - 1);
      byte_queue.push_back(it);
    end
    bytes_queued += member_bytes.size();
    members_sent++;
    member_bytes.delete();
  endtask

  task automatic queue_member(input member_shape_t shape);
    logic [4:0] flg;
    int         n, k;
    flg = 5'($urandom);
    member_bytes.push_back(MAGIC_BYTE0);
    member_bytes.push_back(MAGIC_BYTE1);
    member_bytes.push_back(METHOD_DEFLATE);
    member_bytes.push_back({3'b000, flg});
    repeat (6) member_bytes.push_back(8'($urandom));
    if (flg[FL_EXTRA_BIT]) begin
      n = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
      member_bytes.push_back(8'(n));
      member_bytes.push_back(8'h00);
      repeat (n) member_bytes.push_back(8'($urandom));
    end
    if (flg[FL_NAME_BIT]) begin
      repeat ($urandom_range(0, 5)) member_bytes.push_back(8'($urandom_range(1, 255)));
      member_bytes.push_back(8'h00);
    end
    if (flg[FL_COMMENT_BIT]) begin
      repeat ($urandom_range(0, 5)) member_bytes.push_back(8'($urandom_range(1, 255)));
      member_bytes.push_back(8'h00);
    end
    if (flg[FL_HCRC_BIT]) repeat (2) member_bytes.push_back(8'($urandom));
    // payload plus trailer; a few members carry almost nothing
    n = ($urandom_range(4) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 28);
    repeat (n + TAIL_LEN) member_bytes.push_back(8'($urandom));
    case (shape)
      MB_CUT: begin
        k = $urandom_range(1, member_bytes.size() - 1);
        while (member_bytes.size() > k) void'(member_bytes.pop_back());
      end
      MB_BAD: begin
        k = $urandom_range(3);
        case (k)
          0: member_bytes[0] = MAGIC_BYTE0 ^ 8'($urandom_range(1, 255));
          1: member_bytes[1] = MAGIC_BYTE1 ^ 8'($urandom_range(1, 255));
          2: member_bytes[2] = METHOD_DEFLATE ^ 8'($urandom_range(1, 255));
          default: member_bytes[3] = member_bytes[3] | (8'h20 << $urandom_range(2));
        endcase
        // sometimes the bad byte is the marked one
        k = $urandom_range(k + 1, member_bytes.size());
        while (member_bytes.size() > k) void'(member_bytes.pop_back());
      end
      MB_NOISE: begin
        member_bytes.delete();
        repeat ($urandom_range(1, 12)) member_bytes.push_back(8'($urandom));
      end
      default: ;
    endcase
    flush_member();
  endtask

  // settle past the driver's falling-edge update before looking at in_tvalid
  task automatic drain();
    do begin
      @(negedge clk);
      #1;
    end while (byte_queue.size() != 0 || in_tvalid || due_results.size() != 0);
  endtask

  initial begin
    int target, pick;
    clear_deframer();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: bad magic on the marked byte, bad second magic with dropped
    // bytes, bad method, reserved flag on the marked byte, header cut short
    member_bytes = '{8'h00};
    flush_member();
    member_bytes = '{8'h1f, 8'hff, 8'h1f, 8'h8b};
    flush_member();
    member_bytes = '{8'h1f, 8'h8b, 8'h09};
    flush_member();
    member_bytes = '{8'h1f, 8'h8b, 8'h08, 8'he0};
    flush_member();
    member_bytes = '{8'h1f, 8'h8b, 8'h08, 8'h01, 8'h00};
    flush_member();

    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      target = bytes_queued + 135;
      while (bytes_queued < target) begin
        pick = $urandom_range(99);
        if (pick < 60) queue_member(MB_GOOD);
        else if (pick < 75) queue_member(MB_CUT);
        else if (pick < 90) queue_member(MB_BAD);
        else queue_member(MB_NOISE);
      end
      drain();
    end

    repeat (20) @(negedge clk);
    $display("Ran %0d members (%0d bytes) through four idle/stall mixes;", members_sent,
             bytes_queued);
    $display("checked %0d payload bytes and %0d status items, %0d mismatches", payload_seen,
             status_seen, mismatches);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (due_results.size() != 0) $display("%0d results never arrived", due_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout: %0d bytes pending, %0d results outstanding", byte_queue.size(),
             due_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
